### src/assert_macros.svh
// Assertion macros shared by the sighting table RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication or plain property, clocked on clk_i, off in reset
`define TST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// next-cycle implication
`define TST_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### src/tst_pkg.sv
// Types and constants of the sighting table
package tst_pkg;

  localparam int KIND_W  = 2;
  localparam int ID_W    = 48;
  localparam int BAT_W   = 8;
  localparam int STEP_W  = 24;
  localparam int RSSI_W  = 8;
  localparam int IDX_W   = 6;
  localparam int TIME_W  = 32;
  localparam int STAT_W  = 3;
  localparam int POS_W   = 6;
  localparam int TOT_W   = 7;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [PADDR_W-1:0] ADDR_MAX_AGE  = 3'd0;
  localparam logic [TIME_W-1:0]  MAX_AGE_RESET = 32'd86400;

  typedef enum logic [KIND_W-1:0] {
    KIND_REPORT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SWEEP  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_DELETED  = 3'd2,
    ST_FULL     = 3'd3,
    ST_BAD_IDX  = 3'd4,
    ST_ZERO_ID  = 3'd5,
    ST_SWEPT    = 3'd6
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] stamp;
    logic [BAT_W-1:0]  bat;
    logic [STEP_W-1:0] steps;
    logic [RSSI_W-1:0] rssi;
  } entry_t;

  typedef struct packed {
    logic load;
    logic step;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic done;
  } sts_t;

endpackage

### src/tst_if.sv
// Request and response word channels of the sighting table
interface tst_req_if import tst_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [ID_W-1:0]          tag_id;
  logic [BAT_W-1:0]         battery;
  logic [STEP_W-1:0]        step_count;
  logic signed [RSSI_W-1:0] signal_strength;
  logic [IDX_W-1:0]         target_index;
  logic [TIME_W-1:0]        now_seconds;

  modport source (output valid, kind, tag_id, battery, step_count, signal_strength,
                  target_index, now_seconds, input ready);
  modport sink (input valid, kind, tag_id, battery, step_count, signal_strength,
                target_index, now_seconds, output ready);
endinterface

interface tst_rsp_if import tst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [POS_W-1:0]  entry_position;
  logic [TOT_W-1:0]  entry_total;
  logic [TOT_W-1:0]  removed_total;

  modport source (output valid, status, entry_position, entry_total, removed_total,
                  input ready);
  modport sink (input valid, status, entry_position, entry_total, removed_total,
                output ready);
endinterface

### src/tag_sighting_table.sv
// Top level of the sighting table: channels, APB register, controller and datapath
// Keeps up to TABLE_DEPTH sightings packed at positions 0..entry_total-1. One word is
// handled at a time: a report walks the memory until its ID hits, a delete copies each
// later entry down one slot, a sweep reads every entry once and writes survivors back
// compacted. Each walk reads one entry per cycle from the single entry memory, and a new
// word is taken once the response is consumed.
// max_age_seconds sits at APB address 0 and must only be written while idle.
`include "assert_macros.svh"
module tag_sighting_table import tst_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  tst_req_if.sink            req_i,
  tst_rsp_if.source          rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cmd_t              cmd;
  sts_t              sts;
  logic              req_ready, rsp_valid;
  logic [TIME_W-1:0] max_age_q;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MAX_AGE) ? max_age_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q <= MAX_AGE_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_MAX_AGE)) begin
      max_age_q <= pwdata;
    end
  end

  assign req_i.ready = req_ready;
  assign rsp_o.valid = rsp_valid;

  tst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_kind_i  (req_i.kind),
    .req_ready_o (req_ready),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  tst_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .kind_i            (req_i.kind),
    .tag_id_i          (req_i.tag_id),
    .battery_i         (req_i.battery),
    .step_count_i      (req_i.step_count),
    .signal_strength_i (req_i.signal_strength),
    .target_index_i    (req_i.target_index),
    .now_seconds_i     (req_i.now_seconds),
    .max_age_i         (max_age_q),
    .status_o          (rsp_o.status),
    .entry_position_o  (rsp_o.entry_position),
    .entry_total_o     (rsp_o.entry_total),
    .removed_total_o   (rsp_o.removed_total)
  );

  `TST_ASSERT(a_one_side, !(req_ready && rsp_valid), "accepting while response pending")
  `TST_ASSERT_NEXT(a_rsp_done, rsp_valid && rsp_o.ready, req_ready, "not idle after response")
  `TST_ASSERT(a_step_fin, !(cmd.step && cmd.fin), "step and finish together")

endmodule

### src/tst_ctrl.sv
// Sequencer of the sighting table: accept, walk, finish, respond
`include "assert_macros.svh"
module tst_ctrl import tst_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic [KIND_W-1:0] req_kind_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output cmd_t              cmd_o,
  input  sts_t              sts_i
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN, S_OUT} state_e;
  state_e state_q;

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_OUT);
  assign cmd_o.load  = req_ready_o && req_valid_i && (kind_e'(req_kind_i) != KIND_NONE);
  assign cmd_o.step  = (state_q == S_RUN) && !sts_i.done;
  assign cmd_o.fin   = (state_q == S_FIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: if (cmd_o.load) state_q <= S_RUN;
        S_RUN:  if (sts_i.done) state_q <= S_FIN;
        S_FIN:  state_q <= S_OUT;
        S_OUT:  if (rsp_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `TST_ASSERT_NEXT(a_load_runs, cmd_o.load, state_q == S_RUN, "load did not start walk")
  `TST_ASSERT_NEXT(a_fin_out, cmd_o.fin, rsp_valid_o, "finish not followed by response")

endmodule

### src/tst_dp.sv
// Datapath of the sighting table: entry memory, walk counters, result word
`include "assert_macros.svh"
module tst_dp import tst_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  input  logic [KIND_W-1:0]        kind_i,
  input  logic [ID_W-1:0]          tag_id_i,
  input  logic [BAT_W-1:0]         battery_i,
  input  logic [STEP_W-1:0]        step_count_i,
  input  logic signed [RSSI_W-1:0] signal_strength_i,
  input  logic [IDX_W-1:0]         target_index_i,
  input  logic [TIME_W-1:0]        now_seconds_i,
  input  logic [TIME_W-1:0]        max_age_i,
  output logic [STAT_W-1:0]        status_o,
  output logic [POS_W-1:0]         entry_position_o,
  output logic [TOT_W-1:0]         entry_total_o,
  output logic [TOT_W-1:0]         removed_total_o
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int XW = ((CW > IDX_W) ? CW : IDX_W) + 1;

  entry_t mem [TABLE_DEPTH];

  kind_e              kind_q;
  logic [ID_W-1:0]    id_q;
  logic [BAT_W-1:0]   bat_q;
  logic [STEP_W-1:0]  steps_q;
  logic [RSSI_W-1:0]  rssi_q;
  logic [IDX_W-1:0]   tgt_q;
  logic [TIME_W-1:0]  now_q;
  logic [CW-1:0]      cnt_q, ptr_q, ridx_q, keep_q, rem_q, fidx_q;
  logic               rvld_q, found_q;
  entry_t             rdata_q;
  logic [STAT_W-1:0]  res_st_q;
  logic [POS_W-1:0]   res_pos_q;
  logic [TOT_W-1:0]   res_rem_q;

  logic               in_range, rd_en, aged, hit, bad_idx, zero_id, full;
  logic               we;
  logic [AW-1:0]      waddr;
  entry_t             wdata, new_entry;

  assign in_range  = ptr_q < cnt_q;
  assign rd_en     = cmd_i.step && in_range;
  assign aged      = (rdata_q.stamp <= now_q) && ((now_q - rdata_q.stamp) >= max_age_i);
  assign hit       = rvld_q && (rdata_q.id == id_q);
  assign bad_idx   = XW'(tgt_q) >= XW'(cnt_q);
  assign zero_id   = (id_q == '0);
  assign full      = cnt_q >= CW'(TABLE_DEPTH);
  assign new_entry = '{id: id_q, stamp: now_q, bat: bat_q, steps: steps_q, rssi: rssi_q};

  always_comb begin
    unique case (kind_q)
      KIND_REPORT: sts_o.done = zero_id || found_q || (!in_range && !rvld_q);
      KIND_DELETE: sts_o.done = bad_idx || (!in_range && !rvld_q);
      default:     sts_o.done = !in_range && !rvld_q;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = keep_q[AW-1:0];
    wdata = rdata_q;
    priority if (cmd_i.step && rvld_q && (kind_q == KIND_SWEEP)) begin
      we = !aged;
    end else if (cmd_i.step && rvld_q && (kind_q == KIND_DELETE)) begin
      we    = 1'b1;
      waddr = AW'(ridx_q - CW'(1));
    end else if (cmd_i.fin && (kind_q == KIND_REPORT) && !zero_id) begin
      wdata = new_entry;
      waddr = found_q ? fidx_q[AW-1:0] : cnt_q[AW-1:0];
      we    = found_q || !full;
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rdata_q <= mem[ptr_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q    <= tag_id_i;
      bat_q   <= battery_i;
      steps_q <= step_count_i;
      rssi_q  <= signal_strength_i;
      tgt_q   <= target_index_i;
      now_q   <= now_seconds_i;
    end
    if (cmd_i.step) ridx_q <= ptr_q;
    if (cmd_i.step && !found_q && hit) fidx_q <= ridx_q;
    if (cmd_i.fin) begin
      res_pos_q <= '0;
      res_rem_q <= '0;
      unique case (kind_q)
        KIND_REPORT: begin
          priority if (zero_id) begin
            res_st_q <= ST_ZERO_ID;
          end else if (found_q) begin
            res_st_q  <= ST_UPDATED;
            res_pos_q <= POS_W'(fidx_q);
          end else if (full) begin
            res_st_q <= ST_FULL;
          end else begin
            res_st_q  <= ST_INSERTED;
            res_pos_q <= POS_W'(cnt_q);
          end
        end
        KIND_DELETE: begin
          if (bad_idx) begin
            res_st_q <= ST_BAD_IDX;
          end else begin
            res_st_q  <= ST_DELETED;
            res_pos_q <= tgt_q;
            res_rem_q <= TOT_W'(1);
          end
        end
        default: begin
          res_st_q  <= ST_SWEPT;
          res_rem_q <= TOT_W'(rem_q);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= KIND_REPORT;
      cnt_q   <= '0;
      ptr_q   <= '0;
      keep_q  <= '0;
      rem_q   <= '0;
      rvld_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        kind_q  <= kind_e'(kind_i);
        ptr_q   <= (kind_e'(kind_i) == KIND_DELETE) ? CW'(target_index_i) + CW'(1) : '0;
        keep_q  <= '0;
        rem_q   <= '0;
        rvld_q  <= 1'b0;
        found_q <= 1'b0;
      end else if (cmd_i.step) begin
        rvld_q <= in_range;
        if (in_range) ptr_q <= ptr_q + CW'(1);
        if (hit) found_q <= 1'b1;
        if (rvld_q && (kind_q == KIND_SWEEP)) begin
          if (aged) rem_q <= rem_q + CW'(1);
          else keep_q <= keep_q + CW'(1);
        end
      end else if (cmd_i.fin) begin
        unique case (kind_q)
          KIND_REPORT: if (!zero_id && !found_q && !full) cnt_q <= cnt_q + CW'(1);
          KIND_DELETE: if (!bad_idx) cnt_q <= cnt_q - CW'(1);
          default:     cnt_q <= keep_q;
        endcase
      end
    end
  end

  assign status_o         = res_st_q;
  assign entry_position_o = res_pos_q;
  assign entry_total_o    = TOT_W'(cnt_q);
  assign removed_total_o  = res_rem_q;

  `TST_ASSERT(a_cnt_bound, cnt_q <= CW'(TABLE_DEPTH), "fill count above depth")
  `TST_ASSERT_NEXT(a_sweep_cnt, cmd_i.fin && (kind_q == KIND_SWEEP),
                   cnt_q == $past(keep_q), "sweep left wrong fill count")

endmodule
